[rtl/core/triple_array_trie_word_lookup_defines.svh]
// Assertion macros for the checker file of the trie lookup block.
`ifndef TRIPLE_ARRAY_TRIE_WORD_LOOKUP_DEFINES_SVH
`define TRIPLE_ARRAY_TRIE_WORD_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TATWL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TATWL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tatwl_pkg.sv]
package tatwl_pkg;

    // Field widths of the transactions and of the trie tables
    localparam int SYM_W     = 8;
    localparam int IDX_W     = 12;
    localparam int BASE_W    = 13;
    localparam int CHK_W     = 13;
    localparam int NEXT_W    = 12;
    localparam int STATE_W   = 12;
    localparam int MAX_DEPTH = 4096;

    // Action codes of an input transaction (code 3 is ignored)
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_SYMBOL = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    // Check value of a slot that belongs to no parent
    localparam logic [CHK_W-1:0] CHECK_UNSET = '1;

    // One trie table entry
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic              term;
        logic [CHK_W-1:0]  check;
        logic [NEXT_W-1:0] next;
    } t_entry;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BASE,
        S_CHECK,
        S_END
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_en;     // write the reset value at the clear counter
        logic ent_wr;     // write the entry of the current transaction
        logic rd_state;   // read the table at the current state
        logic sym_load;   // capture the symbol of the current transaction
        logic base_eval;  // form the slot from base and symbol, read it if valid
        logic chk_eval;   // compare check with state, advance or mark failed
        logic out_load;   // load the result register and restart the walk
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;   // clear counter is at the last entry
        logic failed;     // walk has already missed
        logic slot_ok;    // state, symbol and slot are all in range
        logic out_free;   // result register can take a result this cycle
    } t_status;

endpackage

[rtl/core/tatwl_in_if.sv]
interface tatwl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            action;
    logic [tatwl_pkg::SYM_W-1:0]           symbol;
    logic [tatwl_pkg::IDX_W-1:0]           entry_index;
    logic signed [tatwl_pkg::BASE_W-1:0]   entry_base;
    logic                                  entry_term;
    logic signed [tatwl_pkg::CHK_W-1:0]    entry_check;
    logic [tatwl_pkg::NEXT_W-1:0]          entry_next;

    modport source (
        output valid, action, symbol, entry_index, entry_base, entry_term,
               entry_check, entry_next,
        input  ready
    );

    modport sink (
        input  valid, action, symbol, entry_index, entry_base, entry_term,
               entry_check, entry_next,
        output ready
    );
endinterface

[rtl/core/tatwl_out_if.sv]
interface tatwl_out_if;
    logic valid;
    logic ready;
    logic is_word;

    modport source (
        output valid, is_word,
        input  ready
    );

    modport sink (
        input  valid, is_word,
        output ready
    );
endinterface

[rtl/core/triple_array_trie_word_lookup.sv]
// Word membership lookup over a triple-array trie (base, check, next tables plus a
// terminal flag per state). A write transaction loads one table slot; slots at or
// above min(NUM_STATES, 4096) are dropped. The table is one synchronous single-read-
// port memory, so a symbol step first reads the base of the current state and then
// the check and next of the slot it selects; the second read is skipped when the
// state, symbol or slot is out of range. Symbols after a miss, and unknown actions,
// are taken without a table read. An end transaction waits for the result register,
// then returns is_word and restarts the walk at state zero. After reset a clearing
// pass over min(NUM_STATES, 4096) slots sets every slot to its empty value; no input
// is taken until it finishes. A finished result waits in its own register while
// writes and symbols keep flowing.
module triple_array_trie_word_lookup #(
    parameter int NUM_STATES    = 4096,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tatwl_in_if.sink     i_in,
    tatwl_out_if.source  o_out
);

    tatwl_pkg::t_cmd    w_cmd;
    tatwl_pkg::t_status w_status;
    logic               w_in_ready;
    logic               w_out_valid;
    logic               w_is_word;

    // Sequencer
    tatwl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Table, walk registers and result register
    tatwl_dp #(
        .NUM_STATES    (NUM_STATES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_symbol      (i_in.symbol),
        .i_entry_index (i_in.entry_index),
        .i_entry_base  (i_in.entry_base),
        .i_entry_term  (i_in.entry_term),
        .i_entry_check (i_in.entry_check),
        .i_entry_next  (i_in.entry_next),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (w_out_valid),
        .o_is_word     (w_is_word),
        .o_status      (w_status)
    );

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = w_out_valid;
    assign o_out.is_word = w_is_word;

endmodule

[rtl/core/tatwl_ctrl.sv]
module tatwl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_action,
    input  tatwl_pkg::t_status i_status,
    output logic               o_in_ready,
    output tatwl_pkg::t_cmd    o_cmd
);

    tatwl_pkg::t_state r_fsm;
    tatwl_pkg::t_state n_fsm;

    // State register; reset starts the table clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= tatwl_pkg::S_CLEAR;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    // Next state and commands
    always_comb begin
        n_fsm      = r_fsm;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_fsm)
            tatwl_pkg::S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_status.clr_last) begin
                    n_fsm = tatwl_pkg::S_IDLE;
                end
            end
            tatwl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_action)
                        tatwl_pkg::ACT_WRITE: begin
                            o_cmd.ent_wr = 1'b1;
                        end
                        tatwl_pkg::ACT_SYMBOL: begin
                            // a failed walk ignores symbols until the end
                            if (!i_status.failed) begin
                                o_cmd.rd_state = 1'b1;
                                o_cmd.sym_load = 1'b1;
                                n_fsm          = tatwl_pkg::S_BASE;
                            end
                        end
                        tatwl_pkg::ACT_END: begin
                            o_cmd.rd_state = 1'b1;
                            n_fsm          = tatwl_pkg::S_END;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tatwl_pkg::S_BASE: begin
                o_cmd.base_eval = 1'b1;
                n_fsm = i_status.slot_ok ? tatwl_pkg::S_CHECK : tatwl_pkg::S_IDLE;
            end
            tatwl_pkg::S_CHECK: begin
                o_cmd.chk_eval = 1'b1;
                n_fsm          = tatwl_pkg::S_IDLE;
            end
            tatwl_pkg::S_END: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_fsm          = tatwl_pkg::S_IDLE;
                end
            end
            default: begin
                n_fsm = tatwl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/tatwl_dp.sv]
module tatwl_dp #(
    parameter int NUM_STATES    = 4096,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tatwl_pkg::t_cmd                     i_cmd,
    input  logic [tatwl_pkg::SYM_W-1:0]         i_symbol,
    input  logic [tatwl_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [tatwl_pkg::BASE_W-1:0] i_entry_base,
    input  logic                                i_entry_term,
    input  logic signed [tatwl_pkg::CHK_W-1:0]  i_entry_check,
    input  logic [tatwl_pkg::NEXT_W-1:0]        i_entry_next,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_is_word,
    output tatwl_pkg::t_status                  o_status
);

    // Slots beyond the 12-bit index can never be written or reached
    localparam int DEPTH = (NUM_STATES < tatwl_pkg::MAX_DEPTH) ?
                           NUM_STATES : tatwl_pkg::MAX_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SLOT_W = tatwl_pkg::BASE_W + 1;
    localparam logic [SLOT_W-1:0]           DEPTH_SLOT  = SLOT_W'(DEPTH);
    localparam logic [tatwl_pkg::IDX_W:0]   DEPTH_IDX   = (tatwl_pkg::IDX_W + 1)'(DEPTH);
    localparam logic [tatwl_pkg::SYM_W:0]   ALPHA_LIMIT = (tatwl_pkg::SYM_W + 1)'(ALPHABET_SIZE);
    localparam logic [AW-1:0]               CLR_LAST    = AW'(DEPTH - 1);

    // Trie table: base, terminal flag, check and next in one word
    tatwl_pkg::t_entry r_mem [DEPTH];
    tatwl_pkg::t_entry r_rd_data;

    logic [AW-1:0]                  r_clr_idx;
    logic [tatwl_pkg::STATE_W-1:0]  r_state;
    logic                           r_failed;
    logic [tatwl_pkg::SYM_W-1:0]    r_sym;
    logic                           r_out_valid;
    logic                           r_is_word;

    logic [AW-1:0]                  n_clr_idx;
    logic [tatwl_pkg::STATE_W-1:0]  n_state;
    logic                           n_failed;
    logic                           n_out_valid;

    logic                           w_wr_en;
    logic [AW-1:0]                  w_wr_addr;
    tatwl_pkg::t_entry              w_wr_data;
    logic                           w_rd_en;
    logic [AW-1:0]                  w_rd_addr;
    logic [SLOT_W-1:0]              w_slot;
    logic                           w_state_ok;
    logic                           w_sym_ok;
    logic                           w_slot_ok;
    logic                           w_idx_ok;
    logic                           w_hit;

    // Range checks and slot address t = base[s] + symbol
    assign w_slot     = {r_rd_data.base[tatwl_pkg::BASE_W-1], r_rd_data.base}
                      + {{(SLOT_W - tatwl_pkg::SYM_W){1'b0}}, r_sym};
    assign w_state_ok = {1'b0, r_state} < DEPTH_IDX;
    assign w_sym_ok   = {1'b0, r_sym} < ALPHA_LIMIT;
    assign w_slot_ok  = w_state_ok && w_sym_ok && !w_slot[SLOT_W-1] && (w_slot < DEPTH_SLOT);
    assign w_idx_ok   = {1'b0, i_entry_index} < DEPTH_IDX;
    assign w_hit      = !r_failed && w_state_ok && r_rd_data.term;

    // Write port: clearing pass or entry load
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_clr_idx;
        w_wr_data = '{base: '0, term: 1'b0, check: tatwl_pkg::CHECK_UNSET, next: '0};
        if (i_cmd.clr_en) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.ent_wr && w_idx_ok) begin
            w_wr_en   = 1'b1;
            w_wr_addr = i_entry_index[AW-1:0];
            w_wr_data = '{base: i_entry_base, term: i_entry_term,
                          check: i_entry_check, next: i_entry_next};
        end
    end

    // Read port: current state, or the slot once base is known
    assign w_rd_en   = i_cmd.rd_state || (i_cmd.base_eval && w_slot_ok);
    assign w_rd_addr = i_cmd.base_eval ? w_slot[AW-1:0] : r_state[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Walk state, clear counter and result register
    always_comb begin
        n_clr_idx   = r_clr_idx;
        n_state     = r_state;
        n_failed    = r_failed;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.clr_en) begin
            n_clr_idx = r_clr_idx + AW'(1);
        end
        if (i_cmd.base_eval && !w_slot_ok) begin
            n_failed = 1'b1;
        end
        if (i_cmd.chk_eval) begin
            if ({1'b0, r_state} == r_rd_data.check) begin
                n_state = r_rd_data.next;
            end else begin
                n_failed = 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_state     = '0;
            n_failed    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_state     <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_idx   <= n_clr_idx;
            r_state     <= n_state;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.sym_load) begin
            r_sym <= i_symbol;
        end
        if (i_cmd.out_load) begin
            r_is_word <= w_hit;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_is_word         = r_is_word;
    assign o_status.clr_last = (r_clr_idx == CLR_LAST);
    assign o_status.failed   = r_failed;
    assign o_status.slot_ok  = w_slot_ok;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

[rtl/core/tatwl_checker.sv]
`include "triple_array_trie_word_lookup_defines.svh"

module tatwl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_action,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_is_word
);

    // A stalled result stays offered and unchanged
    `TATWL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `TATWL_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_is_word), "result changed while stalled")

    // An accepted end of word occupies the block, so the input is held off until the result is loaded
    `TATWL_ASSERT_NXT(a_end_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_action == tatwl_pkg::ACT_END), !i_in_ready, "input taken right after end of word")

    // A new result only appears while the input side was held off
    `TATWL_ASSERT_IMP(a_out_after_end, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready), "result without a pending end of word")

endmodule

bind triple_array_trie_word_lookup tatwl_checker u_tatwl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_action   (i_in.action),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_is_word (o_out.is_word)
);
